// File: sv/edrs_pkg.sv
package edrs_pkg;

    // Fixed field widths
    localparam int LABEL_W    = 8;
    localparam int TRACK_BITS = 16;
    localparam int DIST_W     = 16;
    localparam int SUM_W      = 22;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_START_TRACK = 1'b0;   // register index, paddr[2]

    typedef struct packed {
        logic [LABEL_W-1:0]    req_label;
        logic [TRACK_BITS-1:0] req_track;
        logic                  batch_end;
    } req_t;

    typedef struct packed {
        logic [LABEL_W-1:0]    served_label;
        logic [TRACK_BITS-1:0] served_track;
        logic [DIST_W-1:0]     seek_distance;
        logic [SUM_W-1:0]      run_total;
        logic                  dropped_flag;
        logic                  last_served;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// File: sv/elevator_disk_request_scheduler.sv
// Elevator (LOOK) disk request scheduler. Requests (label, track) are loaded
// one word per cycle into a request store of MAX_REQUESTS entries; the word
// with batch_end set closes the batch, and requests beyond capacity are
// dropped and reported through dropped_flag on every result of that batch.
// Service starts at the start_track register (APB, byte address 0) moving
// upward: each step serves the nearest pending track at or above the head
// (at or below while moving down), reversing when none is left, ties going
// to the earliest loaded entry. One result word per served request carries
// label, track, seek distance, the saturating running total and last_served
// on the final one. s_ready is low from the closing word until the last
// result has been handed to the output register. Each served request costs
// one scan of the store through a single subtract/compare unit that sees
// one entry per cycle, and a second scan when the head reverses; the result
// is then issued once the output register is free. An output register holds
// the latest result, so the next load may start while it waits to be taken.
module elevator_disk_request_scheduler #(
    parameter int MAX_REQUESTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  edrs_pkg::req_t                  s_data,
    // result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output edrs_pkg::rsp_t                  m_data,
    // config
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [edrs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [edrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [edrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import edrs_pkg::*;

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int ENT_W = LABEL_W + TRACK_BITS;

    // ---------------------------------------------------------------
    // Config register
    // ---------------------------------------------------------------
    logic [TRACK_BITS-1:0] start_track_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START_TRACK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_track_reg <= '0;
        end else if (cfg_wr) begin
            start_track_reg <= pwdata[TRACK_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_START_TRACK) begin
            prdata[TRACK_BITS-1:0] = start_track_reg;
        end
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [ENT_W-1:0]        store_mem [MAX_REQUESTS];  // {label, track}
    logic [MAX_REQUESTS-1:0] pending_reg;
    logic [CNT_W-1:0]        count_reg;      // loaded entries
    logic [CNT_W-1:0]        remain_reg;     // entries still to serve
    logic [TRACK_BITS-1:0]   head_reg;
    logic                    up_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    overflow_reg;

    // scan pipeline: issue address, then compare registered read data
    logic [CNT_W-1:0]        scan_idx_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic [ENT_W-1:0]        rd_data_reg;

    logic                    best_found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [DIST_W-1:0]       best_dist_reg;
    logic [LABEL_W-1:0]      best_label_reg;
    logic [TRACK_BITS-1:0]   best_track_reg;

    logic                    m_valid_reg;
    rsp_t                    m_data_reg;

    // ---------------------------------------------------------------
    // Shared compare unit: one subtract decides direction eligibility
    // and gives the seek distance.
    // ---------------------------------------------------------------
    logic [TRACK_BITS-1:0] cmp_track;
    logic [TRACK_BITS-1:0] op_a, op_b;
    logic [TRACK_BITS:0]   diff;
    logic                  eligible;
    logic                  better;

    assign cmp_track = rd_data_reg[TRACK_BITS-1:0];
    assign op_a      = up_reg ? cmp_track : head_reg;
    assign op_b      = up_reg ? head_reg  : cmp_track;
    assign diff      = {1'b0, op_a} - {1'b0, op_b};
    assign eligible  = !diff[TRACK_BITS];
    assign better    = cmp_vld_reg && pending_reg[cmp_idx_reg] && eligible &&
                       (!best_found_reg || (diff[DIST_W-1:0] < best_dist_reg));

    // running total, saturating
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;

    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(best_dist_reg);
    assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic load_acc;     // request word taken
    logic store_wr;     // room left for it
    logic batch_go;     // closing word taken
    logic issue;        // read one entry this cycle
    logic scan_start;
    logic flip_dir;
    logic emit_fire;
    logic batch_done;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        load_acc   = 1'b0;
        store_wr   = 1'b0;
        batch_go   = 1'b0;
        issue      = 1'b0;
        scan_start = 1'b0;
        flip_dir   = 1'b0;
        emit_fire  = 1'b0;
        batch_done = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                load_acc = s_valid;
                store_wr = s_valid && (count_reg < CNT_W'(MAX_REQUESTS));
                if (s_valid && s_data.batch_end) begin
                    batch_go   = 1'b1;
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue = (scan_idx_reg < count_reg);
                if (!issue && !cmp_vld_reg) begin
                    if (best_found_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        // nothing left this way: reverse and rescan
                        flip_dir   = 1'b1;
                        scan_start = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_fire = 1'b1;
                    if (remain_reg == CNT_W'(1)) begin
                        batch_done = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // ---------------------------------------------------------------
    // Request store
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[count_reg[IDX_W-1:0]] <= {s_data.req_label, s_data.req_track};
        end
        if (issue) begin
            rd_data_reg <= store_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // Batch state
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            count_reg    <= '0;
            remain_reg   <= '0;
            head_reg     <= '0;
            up_reg       <= 1'b1;
            sum_reg      <= '0;
            overflow_reg <= 1'b0;
        end else begin
            if (store_wr) begin
                pending_reg[count_reg[IDX_W-1:0]] <= 1'b1;
                count_reg <= count_reg + CNT_W'(1);
            end else if (load_acc) begin
                overflow_reg <= 1'b1;
            end
            if (batch_go) begin
                head_reg   <= start_track_reg;
                up_reg     <= 1'b1;
                sum_reg    <= '0;
                remain_reg <= store_wr ? count_reg + CNT_W'(1) : count_reg;
            end
            if (flip_dir) begin
                up_reg <= !up_reg;
            end
            if (batch_done) begin
                // final word out: head keeps the last track, rest clears
                pending_reg  <= '0;
                count_reg    <= '0;
                remain_reg   <= '0;
                head_reg     <= best_track_reg;
                up_reg       <= 1'b1;
                sum_reg      <= '0;
                overflow_reg <= 1'b0;
            end else if (emit_fire) begin
                pending_reg[best_idx_reg] <= 1'b0;
                head_reg   <= best_track_reg;
                sum_reg    <= sum_sat;
                remain_reg <= remain_reg - CNT_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Scan pipeline and best-candidate tracking
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end else if (scan_start) begin
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= issue;
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (better) begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (better) begin
            best_idx_reg   <= cmp_idx_reg;
            best_dist_reg  <= diff[DIST_W-1:0];
            best_label_reg <= rd_data_reg[ENT_W-1:TRACK_BITS];
            best_track_reg <= cmp_track;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_data_reg.served_label   <= best_label_reg;
            m_data_reg.served_track   <= best_track_reg;
            m_data_reg.seek_distance  <= best_dist_reg;
            m_data_reg.run_total      <= sum_sat;
            m_data_reg.dropped_flag   <= overflow_reg;
            m_data_reg.last_served    <= (remain_reg == CNT_W'(1));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/edrs_checker.sv
module edrs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input edrs_pkg::req_t                  s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input edrs_pkg::rsp_t                  m_data,
    input logic                            pready
);
    import edrs_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // closing word stops loading
    a_close_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.batch_end |=> !s_ready)
        else $error("still loading after batch close");

    // loading stops only on a closing word
    a_busy_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_data.batch_end))
        else $error("load stopped without batch close");

    // a non-final result means the batch is still in service
    a_mid_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_served |-> !s_ready)
        else $error("loading during batch service");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind elevator_disk_request_scheduler edrs_checker u_edrs_checker (.*);
